@@ src/ggpc_pkg.sv @@
// Package for the go-to-goal proportional controller.
// Holds widths, register indexes, sequencer states, the CORDIC vector type
// and the arctangent table. Depends on nothing.
`default_nettype none

package ggpc_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int TAB_LEN      = 24;
  localparam int STEPS        = (CORDIC_STEPS > TAB_LEN) ? TAB_LEN : CORDIC_STEPS;
  localparam int IW           = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int TAB_IW       = 5;

  localparam int POS_W  = 16;
  localparam int DIFF_W = POS_W + 1;
  localparam int GUARD  = 4;
  localparam int XW     = 24;
  localparam int ZW     = 18;
  localparam int ERR_W  = ZW + 1;
  localparam int DIST_W = 17;
  localparam int TOL_W  = 15;
  localparam int GAIN_W = 12;
  localparam int LIN_W  = 18;
  localparam int ANG_W  = 20;

  localparam int MA_W = XW + 1;
  localparam int MB_W = 18;
  localparam int MP_W = MA_W + MB_W;

  localparam int PI_Q13    = 25736;
  localparam int INV_K_Q16 = 39797;
  localparam int DIST_SH   = 16 + GUARD;
  localparam int GAIN_SH   = 8;

  localparam int CFG_IW = 3;
  localparam int CFG_DW = 16;

  typedef logic [CFG_IW-1:0] cfg_index_t;

  localparam cfg_index_t REG_GOAL_X      = 3'd0;
  localparam cfg_index_t REG_GOAL_Y      = 3'd1;
  localparam cfg_index_t REG_TOLERANCE   = 3'd2;
  localparam cfg_index_t REG_LINEAR_GAIN = 3'd3;
  localparam cfg_index_t REG_ANGULAR_GAIN = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ITER,
    ST_SCALE,
    ST_DIST,
    ST_LIN,
    ST_ANG,
    ST_DONE
  } ggpc_state_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } ggpc_vec_t;

  function automatic logic signed [ZW-1:0] atan_q13(input logic [TAB_IW-1:0] idx);
    logic signed [ZW-1:0] v;
    unique case (idx)
      5'd0:    v = 18'sd6434;
      5'd1:    v = 18'sd3798;
      5'd2:    v = 18'sd2007;
      5'd3:    v = 18'sd1019;
      5'd4:    v = 18'sd511;
      5'd5:    v = 18'sd256;
      5'd6:    v = 18'sd128;
      5'd7:    v = 18'sd64;
      5'd8:    v = 18'sd32;
      5'd9:    v = 18'sd16;
      5'd10:   v = 18'sd8;
      5'd11:   v = 18'sd4;
      5'd12:   v = 18'sd2;
      5'd13:   v = 18'sd1;
      5'd14:   v = 18'sd1;
      default: v = 18'sd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

@@ src/ggpc_cordic_step.sv @@
// One vectoring CORDIC micro-rotation, shared by every iteration.
// Uses ggpc_pkg for the vector type and the arctangent table.
`default_nettype none

module ggpc_cordic_step (
  input  ggpc_pkg::ggpc_vec_t        vec_i,
  input  logic [ggpc_pkg::IW-1:0]    shift_i,
  output ggpc_pkg::ggpc_vec_t        vec_o
);
  import ggpc_pkg::*;

  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;
  logic signed [ZW-1:0] ang;

  assign xs  = vec_i.x >>> shift_i;
  assign ys  = vec_i.y >>> shift_i;
  assign ang = atan_q13(TAB_IW'(shift_i));

  always_comb begin
    if (vec_i.y >= 0) begin
      vec_o.x = vec_i.x + ys;
      vec_o.y = vec_i.y - xs;
      vec_o.z = vec_i.z + ang;
    end else begin
      vec_o.x = vec_i.x - ys;
      vec_o.y = vec_i.y + xs;
      vec_o.z = vec_i.z - ang;
    end
  end

endmodule

`default_nettype wire

@@ src/go_to_goal_p_controller.sv @@
// Top level of the go-to-goal proportional controller.
// Uses ggpc_pkg and ggpc_cordic_step.
//
//   port group  direction  handshake       contents
//   in_         in         valid / ready   pose_x, pose_y, pose_heading
//   out_        out        valid / ready   linear_cmd, angular_cmd, arrived
//   cfg_        in         write enable    index, 16-bit write data
//
// From acceptance a word passes through the CORDIC iterations on the one
// rotation unit, then the scale, distance, linear and angular steps, where
// the three products share the one multiplier, before its result is loaded.
// A new word is taken only once the sequencer is back in idle.
// Synchronous active-low reset restores the default goal, tolerance and gains
// and clears the arrived latch. A stalled result holds the sequencer at the
// end until the output register frees, and no new word is taken meanwhile.
`default_nettype none

module go_to_goal_p_controller (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [15:0]                  in_pose_x,
  input  logic signed [15:0]                  in_pose_y,
  input  logic signed [15:0]                  in_pose_heading,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [17:0]                  out_linear_cmd,
  output logic signed [19:0]                  out_angular_cmd,
  output logic                                out_arrived,
  input  logic                                cfg_we,
  input  ggpc_pkg::cfg_index_t                cfg_index,
  input  logic [ggpc_pkg::CFG_DW-1:0]         cfg_wdata
);
  import ggpc_pkg::*;

  ggpc_state_t state_r, state_nxt;

  logic signed [POS_W-1:0] goal_x_r, goal_y_r;
  logic [TOL_W-1:0]        tol_r;
  logic [GAIN_W-1:0]       lin_gain_r, ang_gain_r;
  logic                    latch_r;

  ggpc_vec_t               vec_r, vec_step;
  logic [IW-1:0]           iter_r;
  logic signed [POS_W-1:0] hd_r;
  logic [DIST_W-1:0]       dist_r;
  logic signed [MP_W-1:0]  prod_r;
  logic signed [LIN_W-1:0] lin_r;

  logic                    out_valid_r;
  logic signed [LIN_W-1:0] out_lin_r;
  logic signed [ANG_W-1:0] out_ang_r;
  logic                    out_arr_r;

  logic signed [DIFF_W-1:0] dx, dy;
  logic signed [XW-1:0]     xg, yg;
  ggpc_vec_t                vec_init;

  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic signed [MP_W-1:0] mul_p;
  logic signed [ERR_W-1:0] err;

  logic signed [MP_W-1:0] dist_sum, rnd_sum, rnd_sh;
  logic signed [LIN_W-1:0] lin_sat;
  logic signed [ANG_W-1:0] ang_sat;
  logic                    arrive;
  logic                    accept, load_out;

  ggpc_cordic_step u_step (
    .vec_i   (vec_r),
    .shift_i (iter_r),
    .vec_o   (vec_step)
  );

  assign dx = DIFF_W'(goal_x_r) - DIFF_W'(in_pose_x);
  assign dy = DIFF_W'(goal_y_r) - DIFF_W'(in_pose_y);
  assign xg = XW'(dx) <<< GUARD;
  assign yg = XW'(dy) <<< GUARD;

  always_comb begin
    if (dx < 0) begin
      vec_init.x = -xg;
      vec_init.y = -yg;
      vec_init.z = (dy >= 0) ? ZW'(PI_Q13) : -ZW'(PI_Q13);
    end else begin
      vec_init.x = xg;
      vec_init.y = yg;
      vec_init.z = '0;
    end
  end

  assign err = ERR_W'(vec_r.z) - ERR_W'(hd_r);

  always_comb begin
    mul_a = MA_W'(vec_r.x);
    mul_b = MB_W'(INV_K_Q16);
    unique case (state_r)
      ST_LIN: begin
        mul_a = MA_W'(dist_r);
        mul_b = MB_W'(lin_gain_r);
      end
      ST_ANG: begin
        mul_a = MA_W'(err);
        mul_b = MB_W'(ang_gain_r);
      end
      default: begin
        mul_a = MA_W'(vec_r.x);
        mul_b = MB_W'(INV_K_Q16);
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign dist_sum = prod_r + (MP_W'(1) <<< (DIST_SH - 1));
  assign rnd_sum  = prod_r + (MP_W'(1) <<< (GAIN_SH - 1));
  assign rnd_sh   = rnd_sum >>> GAIN_SH;

  always_comb begin
    if (rnd_sh > MP_W'(131071)) begin
      lin_sat = 18'sd131071;
    end else if (rnd_sh < -MP_W'(131072)) begin
      lin_sat = -18'sd131072;
    end else begin
      lin_sat = LIN_W'(rnd_sh);
    end
    if (rnd_sh > MP_W'(524287)) begin
      ang_sat = 20'sd524287;
    end else if (rnd_sh < -MP_W'(524288)) begin
      ang_sat = -20'sd524288;
    end else begin
      ang_sat = ANG_W'(rnd_sh);
    end
  end

  assign arrive   = latch_r || (dist_r <= DIST_W'(tol_r));
  assign accept   = in_valid && in_ready;
  assign load_out = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = ST_ITER;
        end
      end
      ST_ITER: begin
        if (iter_r == IW'(STEPS - 1)) begin
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE: state_nxt = ST_DIST;
      ST_DIST:  state_nxt = ST_LIN;
      ST_LIN:   state_nxt = ST_ANG;
      ST_ANG:   state_nxt = ST_DONE;
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      vec_r  <= vec_init;
      hd_r   <= in_pose_heading;
      iter_r <= '0;
    end else if (state_r == ST_ITER) begin
      vec_r  <= vec_step;
      iter_r <= iter_r + IW'(1);
    end
    if (state_r == ST_SCALE || state_r == ST_LIN || state_r == ST_ANG) begin
      prod_r <= mul_p;
    end
    if (state_r == ST_DIST) begin
      dist_r <= DIST_W'(dist_sum >>> DIST_SH);
    end
    if (state_r == ST_ANG) begin
      lin_r <= lin_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_lin_r <= arrive ? '0 : lin_r;
      out_ang_r <= arrive ? '0 : ang_sat;
      out_arr_r <= arrive;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      goal_x_r   <= 16'sd2048;
      goal_y_r   <= 16'sd2048;
      tol_r      <= 15'd20;
      lin_gain_r <= 12'd384;
      ang_gain_r <= 12'd1024;
      latch_r    <= 1'b0;
    end else begin
      if (load_out) begin
        latch_r <= arrive;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_GOAL_X: begin
            goal_x_r <= signed'(cfg_wdata[POS_W-1:0]);
            latch_r  <= 1'b0;
          end
          REG_GOAL_Y: begin
            goal_y_r <= signed'(cfg_wdata[POS_W-1:0]);
            latch_r  <= 1'b0;
          end
          REG_TOLERANCE:    tol_r      <= cfg_wdata[TOL_W-1:0];
          REG_LINEAR_GAIN:  lin_gain_r <= cfg_wdata[GAIN_W-1:0];
          REG_ANGULAR_GAIN: ang_gain_r <= cfg_wdata[GAIN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_linear_cmd  = out_lin_r;
  assign out_angular_cmd = out_ang_r;
  assign out_arrived     = out_arr_r;

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// Self-checking testbench for go_to_goal_p_controller.
// Drives poses through a bursty valid/ready sender, checks every drive command
// against a behavioral CORDIC predictor. Needs ggpc_pkg and the controller RTL.
`timescale 1ns / 100ps

module tb;
  import ggpc_pkg::*;

  localparam int     CORDIC_ITERS = STEPS;
  localparam longint HALF_TURN    = 25736;
  localparam longint INV_GAIN     = 39797;
  localparam int     IDLE_LIMIT   = 4000;
  localparam int     HOLD_CYCLES  = 400;
  localparam int     SETTLE       = 30;
  localparam int     MAX_REPORTS  = 30;
  localparam int     TARGET_WORDS = 1600;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] heading;
  } pose_t;

  typedef struct packed {
    logic signed [17:0] lin;
    logic signed [19:0] turn;
    logic               arrived;
  } drive_cmd_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_EVERY3
  } rx_mode_t;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [15:0] in_pose_x = '0;
  logic signed [15:0] in_pose_y = '0;
  logic signed [15:0] in_pose_heading = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [17:0] out_linear_cmd;
  logic signed [19:0] out_angular_cmd;
  logic               out_arrived;
  logic               cfg_we = 1'b0;
  cfg_index_t         cfg_index = REG_GOAL_X;
  logic [CFG_DW-1:0]  cfg_wdata = '0;

  go_to_goal_p_controller dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_pose_x       (in_pose_x),
    .in_pose_y       (in_pose_y),
    .in_pose_heading (in_pose_heading),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_linear_cmd  (out_linear_cmd),
    .out_angular_cmd (out_angular_cmd),
    .out_arrived     (out_arrived),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  // Controller state as the predictor sees it.
  logic signed [15:0] tgt_x      = 16'sd2048;
  logic signed [15:0] tgt_y      = 16'sd2048;
  logic [14:0]        arrive_tol = 15'd20;
  logic [11:0]        lin_gain   = 12'd384;
  logic [11:0]        turn_gain  = 12'd1024;
  logic               parked     = 1'b0;

  longint atan_step [0:TAB_LEN-1] = '{6434, 3798, 2007, 1019, 511, 256, 128, 64,
                                      32, 16, 8, 4, 2, 1, 1, 0,
                                      0, 0, 0, 0, 0, 0, 0, 0};

  pose_t      pose_queue [$];
  drive_cmd_t pending_cmds [$];
  int         queued_cnt = 0;
  int         recv_cnt = 0;
  int         errors = 0;
  int         idle_cycles = 0;
  bit         in_took = 1'b0;

  bit         steady = 1'b0;
  int         burst_left = 0;
  int         gap_left = 0;
  pose_t      next_pose;

  int         hold_req_cnt = 0;
  int         hold_seen = 0;
  int         hold_left = 0;
  rx_mode_t   rx_mode = RX_OPEN;
  int         mode_left = 0;
  int         pat_cnt = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic drive_cmd_t predict_cmd(input pose_t p);
    longint dx, dy, vx, vy, sx, sy, ang_z, span, lin, turn;
    int i;
    drive_cmd_t c;
    dx = longint'(tgt_x) - longint'($signed(p.x));
    dy = longint'(tgt_y) - longint'($signed(p.y));
    span = 0;
    ang_z = 0;
    if (dx != 0 || dy != 0) begin
      vx = dx * 16;
      vy = dy * 16;
      if (dx < 0) begin
        vx = -vx;
        vy = -vy;
        ang_z = (dy >= 0) ? HALF_TURN : -HALF_TURN;
      end
      for (i = 0; i < CORDIC_ITERS; i++) begin
        sx = vx >>> i;
        sy = vy >>> i;
        if (vy >= 0) begin
          vx = vx + sy;
          vy = vy - sx;
          ang_z = ang_z + atan_step[i];
        end else begin
          vx = vx - sy;
          vy = vy + sx;
          ang_z = ang_z - atan_step[i];
        end
      end
      span = (vx * INV_GAIN + (longint'(1) <<< 19)) >>> 20;
    end
    if (parked || span <= longint'(arrive_tol)) begin
      parked = 1'b1;
      c.lin = '0;
      c.turn = '0;
      c.arrived = 1'b1;
    end else begin
      lin = (span * longint'(lin_gain) + 128) >>> 8;
      turn = ((ang_z - longint'($signed(p.heading))) * longint'(turn_gain) + 128) >>> 8;
      if (lin > 131071) lin = 131071;
      if (lin < -131072) lin = -131072;
      if (turn > 524287) turn = 524287;
      if (turn < -524288) turn = -524288;
      c.lin = lin[17:0];
      c.turn = turn[19:0];
      c.arrived = 1'b0;
    end
    return c;
  endfunction

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] seen);
    if (seen !== want) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
    end
  endtask

  // Monitor and predictor hookup: everything is sampled at the rising edge.
  always @(posedge clk) begin
    drive_cmd_t want;
    in_took = 1'b0;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        in_took = 1'b1;
        pending_cmds.push_back(predict_cmd('{in_pose_x, in_pose_y, in_pose_heading}));
      end
      if (out_valid && out_ready) begin
        recv_cnt++;
        if (pending_cmds.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: unexpected word, expected none, actual %0d %0d %0d", $time,
                     out_linear_cmd, out_angular_cmd, out_arrived);
        end else begin
          want = pending_cmds.pop_front();
          check_field("linear_cmd", want.lin, out_linear_cmd);
          check_field("angular_cmd", want.turn, out_angular_cmd);
          check_field("arrived", want.arrived, out_arrived);
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
  end

  // Sender: bursts of words with random gaps.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_took)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pose_queue.size() > 0) begin
        next_pose = pose_queue.pop_front();
        in_valid <= 1'b1;
        in_pose_x <= next_pose.x;
        in_pose_y <= next_pose.y;
        in_pose_heading <= next_pose.heading;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 16);
          gap_left = steady ? 0 : $urandom_range(0, 30);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: changing stall patterns plus an occasional long hold-off.
  always @(negedge clk) begin
    if (hold_seen != hold_req_cnt) begin
      hold_seen = hold_req_cnt;
      hold_left = HOLD_CYCLES;
    end
    if (mode_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      mode_left = $urandom_range(20, 300);
    end else begin
      mode_left--;
    end
    pat_cnt++;
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_OPEN:   out_ready <= 1'b1;
        RX_COIN:   out_ready <= ($urandom_range(0, 1) == 1);
        RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
        default:   out_ready <= (pat_cnt % 3 == 0);
      endcase
    end
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(negedge clk);
    $display("FAIL go_to_goal_p_controller");
    $finish;
  end

  task automatic write_reg(input cfg_index_t idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_GOAL_X: begin
        tgt_x = val;
        parked = 1'b0;
      end
      REG_GOAL_Y: begin
        tgt_y = val;
        parked = 1'b0;
      end
      REG_TOLERANCE:    arrive_tol = val[14:0];
      REG_LINEAR_GAIN:  lin_gain = val[11:0];
      REG_ANGULAR_GAIN: turn_gain = val[11:0];
      default: ;
    endcase
  endtask

  task automatic queue_pose(input int x, input int y, input int hd);
    pose_t p;
    p.x = x[15:0];
    p.y = y[15:0];
    p.heading = hd[15:0];
    pose_queue.push_back(p);
    queued_cnt++;
  endtask

  task automatic drain();
    while (recv_cnt != queued_cnt) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  function automatic int clip16(input int v);
    return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
  endfunction

  function automatic int rand16();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic logic [15:0] pick_goal();
    case ($urandom_range(0, 5))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'h0FFF;
      2, 3:    return 16'($urandom_range(256, 1024));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  initial begin
    int phase_no, n_items, k, pick, hd, gx, gy, idx;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: every quadrant, axis cases, saturation and arrival.
    @(posedge clk);
    queue_pose(0, 0, 0);
    queue_pose(-32768, -32768, 32767);
    queue_pose(32767, 32767, -32768);
    queue_pose(32767, 0, 0);
    queue_pose(32767, 2048, 0);
    queue_pose(2048, 0, 12345);
    queue_pose(2048, 32767, -12345);
    queue_pose(0, 2048, 0);
    queue_pose(-20000, 30000, 32767);
    queue_pose(2058, 2048, 0);
    queue_pose(0, 0, 0);
    drain();

    // Largest gains, zero tolerance, saturation in both directions.
    write_reg(REG_GOAL_X, 16'h8000);
    write_reg(REG_GOAL_Y, 16'h7FFF);
    write_reg(REG_TOLERANCE, 16'h0000);
    write_reg(REG_LINEAR_GAIN, 16'h0FFF);
    write_reg(REG_ANGULAR_GAIN, 16'hFFFF);
    @(posedge clk);
    queue_pose(32767, -32768, -32768);
    drain();
    write_reg(REG_GOAL_X, 16'h7FFF);
    write_reg(REG_GOAL_Y, 16'h8000);
    @(posedge clk);
    queue_pose(-32768, 32767, 32767);
    queue_pose(32767, -32768, 0);
    queue_pose(0, 0, 0);
    drain();

    // Largest tolerance, zero gains, writes to unused indexes.
    write_reg(REG_GOAL_X, 16'h0000);
    write_reg(REG_GOAL_Y, 16'h0000);
    write_reg(REG_TOLERANCE, 16'hFFFF);
    write_reg(REG_LINEAR_GAIN, 16'hF000);
    write_reg(REG_ANGULAR_GAIN, 16'hF000);
    for (idx = REG_ANGULAR_GAIN + 1; idx < (1 << CFG_IW); idx++)
      write_reg(cfg_index_t'(idx), 16'($urandom_range(0, 65535)));
    @(posedge clk);
    queue_pose(-32768, -32768, 0);
    queue_pose(5000, 0, 100);
    drain();

    phase_no = 0;
    while (queued_cnt < TARGET_WORDS) begin
      if ($urandom_range(0, 9) != 0) write_reg(REG_GOAL_X, pick_goal());
      if ($urandom_range(0, 2) != 0) write_reg(REG_GOAL_Y, pick_goal());
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 9))
          0:       write_reg(REG_TOLERANCE, 16'h0000);
          1:       write_reg(REG_TOLERANCE, 16'($urandom_range(0, 65535)));
          default: write_reg(REG_TOLERANCE, 16'($urandom_range(0, 300)));
        endcase
      end
      if ($urandom_range(0, 2) != 0) write_reg(REG_LINEAR_GAIN, pick_gain());
      if ($urandom_range(0, 2) != 0) write_reg(REG_ANGULAR_GAIN, pick_gain());
      if ($urandom_range(0, 19) == 0)
        write_reg(cfg_index_t'($urandom_range(REG_ANGULAR_GAIN + 1, (1 << CFG_IW) - 1)),
                  16'($urandom_range(0, 65535)));

      @(posedge clk);
      steady = (phase_no % 7 == 5);
      if (phase_no == 3) hold_req_cnt++;
      gx = int'(tgt_x);
      gy = int'(tgt_y);
      n_items = $urandom_range(25, 60);
      for (k = 0; k < n_items; k++) begin
        pick = $urandom_range(0, 199);
        if ($urandom_range(0, 9) == 0)
          hd = $urandom_range(0, 1) ? 32767 : -32768;
        else
          hd = rand16();
        if (pick < 2)
          queue_pose(gx, gy, hd);
        else if (pick < 5)
          queue_pose(clip16(gx + int'($urandom_range(0, 80)) - 40),
                     clip16(gy + int'($urandom_range(0, 80)) - 40), hd);
        else if (pick < 60)
          queue_pose(clip16(gx + int'($urandom_range(0, 6000)) - 3000),
                     clip16(gy + int'($urandom_range(0, 6000)) - 3000), hd);
        else
          queue_pose(rand16(), rand16(), hd);
      end
      drain();
      phase_no++;
    end

    if (errors == 0)
      $display("PASS go_to_goal_p_controller");
    else
      $display("FAIL go_to_goal_p_controller");
    $finish;
  end

endmodule
